[src/aas_pkg.sv]
// Package for the horizontal area-averaging shrink block.
// Holds shared widths, register indexes, Q14 constants and lane control types.
// No dependencies.
`timescale 1ns / 1ps

package aas_pkg;

   localparam int MAX_CHANNELS = 4;
   localparam int CHANNELS_DEF = 4;
   localparam int PIX_W        = 8;
   localparam int CNT_W        = 23;
   localparam int WORD_W       = 16;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 23;

   localparam logic [CNT_W-1:0]  Q14_ONE      = 23'h004000;
   localparam logic [CNT_W-1:0]  STEP_RESET   = 23'h008000;
   localparam logic [WORD_W-1:0] RECIP_RESET  = 16'h8000;

   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_STEP = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_RECIP = 8'd1;

   // Per-lane control issued by the sequencer each cycle.
   typedef struct packed {
      logic load;    // capture the accepted pixel
      logic acc;     // add the pixel whole to the running sum
      logic split;   // finish the output pixel and keep the remainder
      logic clear;   // start a new row
   } lane_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SPLIT = 3'b010,
      S_SCALE = 3'b100
   } state_type;

endpackage

[src/aas_if.sv]
// Channel interfaces for the area-averaging shrink block: pixel in,
// averaged pixel out, and the register write channel. Depends on aas_pkg.
`timescale 1ns / 1ps

interface aas_req_if;
   logic                   valid;
   logic                   ready;
   logic [aas_pkg::PIX_W-1:0] chan0;
   logic [aas_pkg::PIX_W-1:0] chan1;
   logic [aas_pkg::PIX_W-1:0] chan2;
   logic [aas_pkg::PIX_W-1:0] chan3;
   logic                   row_end;
   modport source (output valid, chan0, chan1, chan2, chan3, row_end, input ready);
   modport sink   (input valid, chan0, chan1, chan2, chan3, row_end, output ready);
endinterface

interface aas_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [aas_pkg::PIX_W-1:0] out0;
   logic [aas_pkg::PIX_W-1:0] out1;
   logic [aas_pkg::PIX_W-1:0] out2;
   logic [aas_pkg::PIX_W-1:0] out3;
   modport source (output valid, out0, out1, out2, out3, input ready);
   modport sink   (input valid, out0, out1, out2, out3, output ready);
endinterface

interface aas_csr_if;
   logic                          valid;
   logic                          ready;
   logic [aas_pkg::CSR_IDX_W-1:0]  index;
   logic [aas_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/aas_lane.sv]
// One channel lane: running sum, split products and the scaled, saturated byte.
// Depends on aas_pkg.
`timescale 1ns / 1ps

module aas_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  aas_pkg::lane_ctl_type         ctl,
   input  logic [aas_pkg::PIX_W-1:0]     pix,
   input  logic [aas_pkg::WORD_W-1:0]    weight_c,
   input  logic [aas_pkg::WORD_W-1:0]    recip,
   output logic [aas_pkg::PIX_W-1:0]     result
);
   import aas_pkg::*;

   localparam int Q_W    = PIX_W + 2;
   localparam int PROD_W = Q_W + WORD_W;

   logic [PIX_W-1:0]    pix_ff, pix_in;
   logic [WORD_W-1:0]   sum_ff, sum_in;
   logic [WORD_W-1:0]   t_ff, t_in;
   logic [Q_W-1:0]      q;
   logic [WORD_W-1:0]   weight_w;
   logic [PROD_W-1:0]   prod_c, prod_w;
   logic [2*WORD_W-1:0] prod_r;
   logic [WORD_W-1:0]   r;

   assign q        = {pix_ff, 2'b00};
   assign weight_w = WORD_W'(Q14_ONE) - weight_c;
   assign prod_c   = PROD_W'(q) * PROD_W'(weight_c);
   assign prod_w   = PROD_W'(q) * PROD_W'(weight_w);

   always_comb begin
      pix_in = ctl.load ? pix : pix_ff;
      t_in   = ctl.split ? sum_ff + WORD_W'(prod_c[PROD_W-1:WORD_W]) : t_ff;
      if (ctl.clear) begin
         sum_in = '0;
      end else if (ctl.acc) begin
         sum_in = sum_ff + WORD_W'(pix);
      end else if (ctl.split) begin
         sum_in = WORD_W'(prod_w[PROD_W-1:WORD_W]);
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
      pix_ff <= pix_in;
      t_ff   <= t_in;
   end

   // Scale the finished sum; a negative 16-bit value clamps to zero.
   assign prod_r = (2*WORD_W)'(t_ff) * (2*WORD_W)'(recip);
   assign r      = prod_r[2*WORD_W-1:WORD_W];

   always_comb begin
      if (r[WORD_W-1]) begin
         result = '0;
      end else if (r > WORD_W'(255)) begin
         result = '1;
      end else begin
         result = r[PIX_W-1:0];
      end
   end
endmodule

[src/aas_merge.sv]
// Merging stage: gathers the lane bytes into one output pixel register.
// Depends on aas_pkg and aas_if.
`timescale 1ns / 1ps

module aas_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic [aas_pkg::PIX_W-1:0] lane_bytes [aas_pkg::MAX_CHANNELS],
   output logic                      room,
   aas_rsp_if.source                 rsp_bus
);
   import aas_pkg::*;

   logic             valid_ff, valid_in;
   logic [PIX_W-1:0] out_ff [MAX_CHANNELS];
   logic [PIX_W-1:0] out_in [MAX_CHANNELS];

   assign room = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         out_in[i] = load ? lane_bytes[i] : out_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.out0  = out_ff[0];
   assign rsp_bus.out1  = out_ff[1];
   assign rsp_bus.out2  = out_ff[2];
   assign rsp_bus.out3  = out_ff[3];
endmodule

[src/area_average_shrink_x.sv]
// Horizontal area-averaging shrink, one lane per channel. A pixel that only adds
// to the sums is taken in the idle state; a pixel that completes an output pixel
// passes the accept, split and scale states; the merge stage registers its result.
// Throughput: 1 pixel per cycle while summing; at output pixels the input waits,
// held by the two registered multiplies; a stalled output holds the scale step.
// Synchronous reset loads the span counter, pixel_step and step_reciprocal with
// 0x8000 and clears the sums and output valid.
`timescale 1ns / 1ps

module area_average_shrink_x #(
   parameter int CHANNELS = aas_pkg::CHANNELS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   aas_req_if.sink   req_bus,
   aas_rsp_if.source rsp_bus,
   aas_csr_if.sink   csr_bus
);
   import aas_pkg::*;

   // Configuration registers. Writes must come only while the block is idle; the block itself does not enforce this.
   logic [CNT_W-1:0]  step_ff, step_in;
   logic [WORD_W-1:0] recip_ff, recip_in;
   logic              step_write;

   // Span counter: how much of the current output pixel is still uncovered.
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] weight_ff, weight_in;
   logic              row_end_ff, row_end_in;
   state_type         state_ff, state_in;

   logic              req_xfer;
   logic              summing;
   logic              room;
   logic              merge_load;
   lane_ctl_type      lane_ctl;
   logic [PIX_W-1:0]  pix [MAX_CHANNELS];
   logic [PIX_W-1:0]  lane_bytes [MAX_CHANNELS];

   assign csr_bus.ready = 1'b1;
   assign step_write    = csr_bus.valid && (csr_bus.index == REG_PIXEL_STEP);

   always_comb begin
      step_in  = step_ff;
      recip_in = recip_ff;
      if (step_write) begin
         step_in = csr_bus.data;
      end
      if (csr_bus.valid && (csr_bus.index == REG_STEP_RECIP)) begin
         recip_in = csr_bus.data[WORD_W-1:0];
      end
   end

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   // A pixel that fits whole inside the current output pixel is only summed.
   assign summing       = (cnt_ff > Q14_ONE);
   assign merge_load    = (state_ff == S_SCALE) && room;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      weight_in  = weight_ff;
      row_end_in = row_end_ff;
      lane_ctl   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               lane_ctl.load = 1'b1;
               row_end_in    = req_bus.row_end;
               if (summing) begin
                  lane_ctl.acc   = 1'b1;
                  lane_ctl.clear = req_bus.row_end;
                  cnt_in         = cnt_ff - Q14_ONE;
               end else begin
                  weight_in = cnt_ff[WORD_W-1:0];
                  cnt_in    = cnt_ff + step_ff - Q14_ONE;
                  state_in  = S_SPLIT;
               end
               if (req_bus.row_end) begin
                  cnt_in = step_ff;
               end
            end
         end
         S_SPLIT: begin
            // The finishing sum is taken before a row end clears the lanes.
            lane_ctl.split = 1'b1;
            lane_ctl.clear = row_end_ff;
            state_in       = S_SCALE;
         end
         S_SCALE: begin
            if (room) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // A new step also starts a new row.
      if (step_write) begin
         cnt_in         = csr_bus.data;
         lane_ctl.clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= STEP_RESET;
         recip_ff <= RECIP_RESET;
         cnt_ff   <= STEP_RESET;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         recip_ff <= recip_in;
         cnt_ff   <= cnt_in;
      end
      weight_ff  <= weight_in;
      row_end_ff <= row_end_in;
   end

   assign pix[0] = req_bus.chan0;
   assign pix[1] = req_bus.chan1;
   assign pix[2] = req_bus.chan2;
   assign pix[3] = req_bus.chan3;

   // One lane per configured channel; missing channels report zero.
   for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
      if (g < CHANNELS) begin : g_on
         aas_lane u_lane (
            .clock    (clock),
            .reset    (reset),
            .ctl      (lane_ctl),
            .pix      (pix[g]),
            .weight_c (weight_ff),
            .recip    (recip_ff),
            .result   (lane_bytes[g])
         );
      end else begin : g_off
         assign lane_bytes[g] = '0;
      end
   end

   aas_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (merge_load),
      .lane_bytes (lane_bytes),
      .room       (room),
      .rsp_bus    (rsp_bus)
   );
endmodule

[src/aas_checker.sv]
// Port-level checks for the area-averaging shrink block, bound to the top level.
// Depends on aas_pkg and area_average_shrink_x.
`timescale 1ns / 1ps

module aas_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [aas_pkg::PIX_W-1:0] rsp_out0,
   input logic [aas_pkg::PIX_W-1:0] rsp_out3
);
   import aas_pkg::*;

   // A result held back by the sink keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out0) && $stable(rsp_out3))
      else $error("held output changed");

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output valid after reset");

   // A new result is only produced while the input side is busy finishing it.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a completing pixel");

   // A busy block with a stalled output cannot take a new pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !req_ready |=> !req_ready)
      else $error("input reopened while result stalled");
endmodule

bind area_average_shrink_x aas_checker u_aas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_out0  (rsp_bus.out0),
   .rsp_out3  (rsp_bus.out3)
);

[verif/tb_area_average_shrink_x.sv]
// Self-checking testbench for the horizontal area-averaging shrink block.
// Depends on aas_pkg, the channel interfaces in aas_if and the top level
// area_average_shrink_x.
`timescale 1ns / 1ps

module tb_area_average_shrink_x;
   import aas_pkg::*;

   localparam int CHANNELS = CHANNELS_DEF;

   // Stimulus sizing. The random part starts no new phase once this many pixels are sent.
   localparam int ITEM_TARGET   = 1250;
   // A pixel that only adds to the sums must settle in the block first;
   // this is how long we let it settle before touching the registers.
   localparam int SETTLE_CYCLES = 8;
   // Drained once in a while between pixels, on a count of transfers.
   localparam int DRAIN_PERIOD  = 317;

   typedef struct packed {
      logic                                row_end;
      logic [MAX_CHANNELS-1:0][PIX_W-1:0] chan;
   } src_pixel_type;

   typedef struct packed {
      logic [MAX_CHANNELS-1:0][PIX_W-1:0] chan;
   } avg_pixel_type;

   // The scoreboard keeps its own copy of the registers and of the span and
   // sum state, works out each output pixel that an accepted source pixel
   // finishes, and compares the block's output pixels in order.
   class shrink_scoreboard_type;
      logic [CNT_W-1:0]  step;
      logic [WORD_W-1:0] recip;
      logic [CNT_W-1:0]  span;
      logic [WORD_W-1:0] sums [MAX_CHANNELS];
      avg_pixel_type     expected_pixels [$];
      int                errors;

      function new();
         step         = STEP_RESET;
         recip        = RECIP_RESET;
         errors       = 0;
         start_row();
      endfunction

      function void start_row();
         int i;
         span = step;
         for (i = 0; i < MAX_CHANNELS; i++) sums[i] = '0;
      endfunction

      // High half of an unsigned 16 x 16 product.
      function logic [WORD_W-1:0] mul_hi(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
         logic [2*WORD_W-1:0] prod;
         prod = a * b;
         return prod[2*WORD_W-1:WORD_W];
      endfunction

      function void note_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == REG_PIXEL_STEP) begin
            step = data[CNT_W-1:0];
            start_row();
         end else if (idx == REG_STEP_RECIP) begin
            recip = data[WORD_W-1:0];
         end
      endfunction

      function void predict_pixel(src_pixel_type p);
         avg_pixel_type     o;
         logic [WORD_W-1:0] c;
         logic [WORD_W-1:0] w;
         logic [WORD_W-1:0] q;
         logic [WORD_W-1:0] t;
         logic [WORD_W-1:0] r;
         int                i;
         o = '0;
         if (span > Q14_ONE) begin
            for (i = 0; i < CHANNELS; i++) sums[i] = sums[i] + {8'h00, p.chan[i]};
            span = span - Q14_ONE;
         end else begin
            // Only the low half of the counter weighs the split.
            c = span[WORD_W-1:0];
            w = Q14_ONE[WORD_W-1:0] - c;
            for (i = 0; i < CHANNELS; i++) begin
               q = {6'b000000, p.chan[i], 2'b00};
               t = sums[i] + mul_hi(q, c);
               r = mul_hi(t, recip);
               if (r[WORD_W-1])
                  o.chan[i] = '0;
               else if (r > 16'd255)
                  o.chan[i] = 8'hFF;
               else
                  o.chan[i] = r[PIX_W-1:0];
               sums[i] = mul_hi(q, w);
            end
            span = span + step - Q14_ONE;
            expected_pixels.push_back(o);
         end
         if (p.row_end) start_row();
      endfunction

      function void check_result(avg_pixel_type got);
         avg_pixel_type want;
         int            i;
         if (expected_pixels.size() == 0) begin
            $display("%0t: output pixel %h with none expected", $time, got);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         for (i = 0; i < MAX_CHANNELS; i++) begin
            if (got.chan[i] !== want.chan[i]) begin
               $display("%0t: out%0d expected %0d actual %0d",
                        $time, i, want.chan[i], got.chan[i]);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   aas_req_if req_if ();
   aas_rsp_if rsp_if ();
   aas_csr_if csr_if ();

   area_average_shrink_x #(
      .CHANNELS(CHANNELS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_if),
      .rsp_bus(rsp_if),
      .csr_bus(csr_if)
   );

   shrink_scoreboard_type sb = new();

   // While this is set, the sink keeps ready high and no random input gaps are put in.
   // It covers a stretch of the run chosen by the number of source pixels sent so far.
   bit steady = 1'b0;
   int items_sent = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog. A correct run takes a small fraction of this.
   initial begin
      #5_000_000;
      $display("area_average_shrink_x verification failed");
      $finish;
   end

   // Output side. The values read right after the edge are the ones the block
   // saw at that edge, so a transfer is exactly valid and ready both high here.
   // Ready drops in about one cycle of five outside the steady stretch.
   initial begin : output_sink
      avg_pixel_type got;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.chan[0] = rsp_if.out0;
            got.chan[1] = rsp_if.out1;
            got.chan[2] = rsp_if.out2;
            got.chan[3] = rsp_if.out3;
            sb.check_result(got);
         end
         rsp_if.ready <= steady ? 1'b1 : ($urandom_range(99) >= 20);
      end
   end

   function automatic logic [PIX_W-1:0] rand_byte();
      int pick;
      pick = $urandom_range(99);
      if (pick < 20) return 8'h00;
      if (pick < 40) return 8'hFF;
      return PIX_W'($urandom_range(255));
   endfunction

   function automatic src_pixel_type mk_pixel(logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1,
                                              logic [PIX_W-1:0] c2, logic [PIX_W-1:0] c3,
                                              logic re);
      src_pixel_type p;
      p.chan[0] = c0;
      p.chan[1] = c1;
      p.chan[2] = c2;
      p.chan[3] = c3;
      p.row_end = re;
      return p;
   endfunction

   // Lower valid and hold off until every output pixel owed has come out.
   task automatic wait_results();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Before a register write, also let a trailing summing pixel finish.
   task automatic drain_block();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One source pixel transfer, preceded now and then by an idle gap or by a
   // full drain. Valid is left high on return so that back-to-back pixels
   // never see valid lowered and raised in the same step.
   task automatic push_pixel(input src_pixel_type p);
      steady = (items_sent >= 500 && items_sent < 800);
      if (items_sent % DRAIN_PERIOD == DRAIN_PERIOD / 2) begin
         wait_results();
      end else if (!steady && $urandom_range(99) < 20) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.chan0   <= p.chan[0];
      req_if.chan1   <= p.chan[1];
      req_if.chan2   <= p.chan[2];
      req_if.chan3   <= p.chan[3];
      req_if.row_end <= p.row_end;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      sb.predict_pixel(p);
      items_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      sb.note_register(idx, data);
   endtask

   // Register writes happen only with the block drained. A stray write goes
   // to an index past the register list and must change nothing.
   task automatic configure(input bit wr_step, input logic [CNT_W-1:0] step_v,
                            input bit wr_recip, input logic [CSR_DATA_W-1:0] recip_v,
                            input bit wr_stray, input logic [CSR_IDX_W-1:0] stray_idx);
      drain_block();
      if (wr_step) write_reg(REG_PIXEL_STEP, step_v);
      if (wr_stray) write_reg(stray_idx, CSR_DATA_W'($urandom_range(32'h7FFFFF)));
      if (wr_recip) write_reg(REG_STEP_RECIP, recip_v);
      csr_if.valid <= 1'b0;
   endtask

   // A row of random pixels. A clean row ends with exactly one row end; a
   // noisy one drops row ends anywhere and may leave the row open.
   task automatic send_row(input int len, input bit noisy);
      src_pixel_type p;
      int            k;
      for (k = 0; k < len; k++) begin
         p = mk_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte(), 1'b0);
         p.row_end = noisy ? ($urandom_range(99) < 30) : (k == len - 1);
         push_pixel(p);
      end
   endtask

   initial begin : stimulus
      logic [CNT_W-1:0]      step_v;
      logic [CSR_DATA_W-1:0] recip_v;
      logic [WORD_W-1:0]     recip_lo;
      longint                ratio;
      int                    phase;
      int                    pick;
      int                    rows;
      bit                    long_span;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.chan0   = '0;
      req_if.chan1   = '0;
      req_if.chan2   = '0;
      req_if.chan3   = '0;
      req_if.row_end = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = '0;
      csr_if.data    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Reset settings first: two source pixels per output
      // pixel, with full, empty and alternating channel values and a row end.
      push_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      push_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
      push_pixel(mk_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0));
      push_pixel(mk_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0));
      push_pixel(mk_pixel(8'h5A, 8'hA5, 8'hC3, 8'h3C, 1'b1));
      push_pixel(mk_pixel(8'h01, 8'h80, 8'h7F, 8'hFE, 1'b0));

      // A write to the top index must be ignored: the row carries on.
      configure(1'b0, '0, 1'b0, '0, 1'b1, 8'hFF);
      push_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      push_pixel(mk_pixel(8'h80, 8'h40, 8'h20, 8'h10, 1'b0));

      // Step of exactly one source pixel: every pixel finishes an output
      // pixel. The reciprocal write carries junk in the unused upper bits.
      configure(1'b1, Q14_ONE, 1'b1, {7'h7F, 16'hFFFF}, 1'b0, '0);
      push_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      push_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
      push_pixel(mk_pixel(8'h01, 8'h02, 8'h04, 8'h08, 1'b0));
      push_pixel(mk_pixel(8'h80, 8'hC0, 8'hE0, 8'hF0, 1'b1));

      // Step of zero, below the legal range, with a zero reciprocal: the
      // counter wraps around modulo 2^23.
      configure(1'b1, '0, 1'b1, '0, 1'b1, 8'h02);
      push_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      push_pixel(mk_pixel(8'h7F, 8'h80, 8'h01, 8'hFE, 1'b0));
      push_pixel(mk_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0));

      // Smallest legal step with the largest reciprocal.
      configure(1'b1, Q14_ONE + 23'd1, 1'b1, 23'h00FFFF, 1'b0, '0);
      push_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      push_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      push_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      push_pixel(mk_pixel(8'h00, 8'h55, 8'hAA, 8'hFF, 1'b0));

      // New reciprocal in the middle of a row: the span state must survive.
      configure(1'b0, '0, 1'b1, 23'h000001, 1'b0, '0);
      push_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
      push_pixel(mk_pixel(8'h10, 8'h20, 8'h30, 8'h40, 1'b1));
      push_pixel(mk_pixel(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0));

      // Random part, in phases of one register setting each. The first three
      // phases pin the step extremes; the longest step overflows the 16-bit sums.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         long_span = 1'b0;
         case (phase)
            0: step_v = Q14_ONE + 23'd1;
            1: begin
               step_v    = 23'h400000;
               long_span = 1'b1;
            end
            2: begin
               step_v    = 23'h7FFFFF;
               long_span = 1'b1;
            end
            default: begin
               pick = $urandom_range(99);
               if (pick < 10) begin
                  step_v    = CNT_W'($urandom_range(23'h100000, 23'h040001));
                  long_span = 1'b1;
               end else if (pick < 20) begin
                  step_v = CNT_W'($urandom_range(Q14_ONE, 0));
               end else if (pick < 25) begin
                  step_v = Q14_ONE;
               end else begin
                  step_v = CNT_W'($urandom_range(23'h040000, Q14_ONE + 23'd1));
               end
            end
         endcase

         // Half the time the reciprocal 2^30 / step, clamped to 16 bits, else its
         // extremes or a random value, with random bits above the 16 that count.
         pick = $urandom_range(99);
         if (long_span && phase < 3) begin
            recip_lo = 16'hFFFF;
         end else if (pick < 50 && step_v != 0) begin
            ratio    = (64'd1 << 30) / step_v;
            recip_lo = (ratio > 64'hFFFF) ? 16'hFFFF : ratio[WORD_W-1:0];
         end else if (pick < 60) begin
            recip_lo = 16'h0001;
         end else if (pick < 70) begin
            recip_lo = 16'hFFFF;
         end else if (pick < 75) begin
            recip_lo = '0;
         end else begin
            recip_lo = WORD_W'($urandom_range(16'hFFFF));
         end
         recip_v = {(CSR_DATA_W-WORD_W)'($urandom_range(7'h7F)), recip_lo};

         // A phase past the pinned ones sometimes keeps the old step, so
         // that a row left open by a noisy row runs on under a new scale.
         if (phase >= 3 && !long_span && $urandom_range(99) < 20)
            configure(1'b0, step_v, 1'b1, recip_v, $urandom_range(99) < 15,
                      CSR_IDX_W'($urandom_range(255, 2)));
         else
            configure(1'b1, step_v, 1'b1, recip_v, $urandom_range(99) < 15,
                      CSR_IDX_W'($urandom_range(255, 2)));

         if (long_span) begin
            send_row(int'((step_v >> 14) + $urandom_range(20, 1)), 1'b0);
         end else begin
            rows = $urandom_range(4, 2);
            repeat (rows) send_row($urandom_range(48, 1), $urandom_range(99) < 15);
         end
         phase++;
      end

      // Let every owed output pixel come out, then wait the settle time so the
      // block can show anything it should not.
      drain_block();
      if (sb.errors == 0)
         $display("area_average_shrink_x verification clean");
      else
         $display("area_average_shrink_x verification failed");
      $finish;
   end

endmodule

[filelist.f]
src/aas_pkg.sv
src/aas_if.sv
src/aas_lane.sv
src/aas_merge.sv
src/area_average_shrink_x.sv
src/aas_checker.sv
verif/tb_area_average_shrink_x.sv
